FILE: design/gbn_pkg.sv
package gbn_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam logic [15:0] THR_RESET = 16'd56361;

	// controller to datapath
	typedef struct packed {
		logic load;       // store the request box
		logic iter_clr;   // restart the scan index
		logic srch_rd;    // search scan read
		logic pick_rd;    // read the picked box, mark it suppressed
		logic pick_lat;   // latch the picked box
		logic supp_rd;    // overlap scan read
		logic emit;       // drive the pending box out
		logic emit_last;  // ... as the final one of the set
		logic set_clr;    // empty the store
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic found;      // search found a live box
		logic iter_last;  // scan index is at the last held box
		logic pipe_busy;  // overlap pipeline still holds work
	} sts_t;

endpackage

FILE: design/gbn_ctrl.sv
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic last_in,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_SDRN = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_RDB  = 3'd4;
	localparam logic [2:0] ST_LATB = 3'd5;
	localparam logic [2:0] ST_SUPP = 3'd6;
	localparam logic [2:0] ST_SUPW = 3'd7;

	logic [2:0] state_q, state_d;
	logic       have_q, have_d;

	always_comb begin
		state_d = state_q;
		have_d  = have_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_in) begin
						cmd.iter_clr = 1'b1;
						state_d      = ST_SRCH;
					end
				end
			end
			ST_SRCH: begin
				cmd.srch_rd = 1'b1;
				if (sts.iter_last)
					state_d = ST_SDRN;
			end
			ST_SDRN: state_d = ST_DEC;
			ST_DEC: begin
				if (sts.found) begin
					cmd.emit = have_q;
					state_d  = ST_RDB;
				end else begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.set_clr   = 1'b1;
					have_d        = 1'b0;
					state_d       = ST_IDLE;
				end
			end
			ST_RDB: begin
				cmd.pick_rd = 1'b1;
				state_d     = ST_LATB;
			end
			ST_LATB: begin
				cmd.pick_lat = 1'b1;
				cmd.iter_clr = 1'b1;
				have_d       = 1'b1;
				state_d      = ST_SUPP;
			end
			ST_SUPP: begin
				cmd.supp_rd = 1'b1;
				if (sts.iter_last)
					state_d = ST_SUPW;
			end
			ST_SUPW: begin
				if (!sts.pipe_busy) begin
					cmd.iter_clr = 1'b1;
					state_d      = ST_SRCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			have_q  <= have_d;
		end
	end

endmodule

FILE: design/gbn_dpath.sv
module gbn_dpath
	import gbn_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic        [15:0] cfg_wdata,
	input  logic        [15:0] score_in,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] top_in,
	input  logic signed [15:0] right_in,
	input  logic signed [15:0] bottom_in,
	output logic               done,
	output logic        [15:0] score_out,
	output logic signed [15:0] left_out,
	output logic signed [15:0] top_out,
	output logic signed [15:0] right_out,
	output logic signed [15:0] bottom_out,
	output logic               last_out,
	output logic               overflow_out
);

	localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);

	logic [15:0] score_mem [MAX_BOXES];
	logic [63:0] edge_mem  [MAX_BOXES];
	logic        sup_mem   [MAX_BOXES];

	logic [15:0] thr_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [IW-1:0] iter_q;
	logic          full;

	logic [15:0] score_rd_q;
	logic [63:0] edge_rd_q;
	logic        sup_rd_q;
	logic [IW-1:0] addr;

	logic          we;
	logic [IW-1:0] waddr;
	logic          wsup;

	// search
	logic          srch_v_s1;
	logic [IW-1:0] srch_idx_s1;
	logic          found_q;
	logic [IW-1:0] best_q;
	logic [15:0]   bscore_q;

	// picked box
	logic        [15:0] p_score_q;
	logic signed [15:0] p_l_q, p_t_q, p_r_q, p_b_q;

	// overlap pipeline
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [16:0] wd_s2, hd_s2, wa_s2, ha_s2, wb_s2, hb_s2;
	logic signed [33:0] inter_s3, aa_s3, ab_s3;
	logic               pos_s3, pos_s4, pos_s5;
	logic signed [35:0] uni_s4;
	logic signed [33:0] inter_s4, inter_s5;
	logic signed [53:0] prod_s5;
	logic               hit;

	logic signed [15:0] bl, bt, br, bb;
	logic signed [15:0] mnr, mxl, mnb, mxt;

	assign full = (count_q == CW'(MAX_BOXES));

	always_comb begin
		if (cmd.pick_rd)
			addr = best_q;
		else if (cmd.load)
			addr = count_q[IW-1:0];
		else
			addr = iter_q;
	end

	assign hit = v_s5 && pos_s5 &&
		($signed({inter_s5, 16'd0}) > $signed({{2{prod_s5[53]}}, prod_s5}));

	always_comb begin
		we    = 1'b0;
		waddr = addr;
		wsup  = 1'b0;
		if (cmd.load && !full) begin
			we = 1'b1;
		end else if (cmd.pick_rd) begin
			we   = 1'b1;
			wsup = 1'b1;
		end else if (hit) begin
			we    = 1'b1;
			waddr = idx_s5;
			wsup  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			score_mem[addr] <= score_in;
			edge_mem[addr]  <= {bottom_in, right_in, top_in, left_in};
		end
		if (we)
			sup_mem[waddr] <= wsup;
		score_rd_q <= score_mem[addr];
		edge_rd_q  <= edge_mem[addr];
		sup_rd_q   <= sup_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			iter_q    <= '0;
			found_q   <= 1'b0;
			srch_v_s1 <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			done      <= 1'b0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (cmd.set_clr) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (full)
					ovf_q <= 1'b1;
				else
					count_q <= count_q + 1'b1;
			end
			if (cmd.iter_clr)
				iter_q <= '0;
			else if (cmd.srch_rd || cmd.supp_rd)
				iter_q <= iter_q + 1'b1;
			srch_v_s1 <= cmd.srch_rd;
			if (cmd.iter_clr)
				found_q <= 1'b0;
			else if (srch_v_s1 && !sup_rd_q && (!found_q || score_rd_q > bscore_q))
				found_q <= 1'b1;
			v_s1 <= cmd.supp_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		srch_idx_s1 <= iter_q;
		if (srch_v_s1 && !sup_rd_q && (!found_q || score_rd_q > bscore_q)) begin
			best_q   <= srch_idx_s1;
			bscore_q <= score_rd_q;
		end
		if (cmd.pick_lat) begin
			p_score_q <= bscore_q;
			p_l_q     <= edge_rd_q[15:0];
			p_t_q     <= edge_rd_q[31:16];
			p_r_q     <= edge_rd_q[47:32];
			p_b_q     <= edge_rd_q[63:48];
		end
		if (cmd.emit) begin
			score_out    <= p_score_q;
			left_out     <= p_l_q;
			top_out      <= p_t_q;
			right_out    <= p_r_q;
			bottom_out   <= p_b_q;
			last_out     <= cmd.emit_last;
			overflow_out <= ovf_q;
		end
	end

	assign bl = edge_rd_q[15:0];
	assign bt = edge_rd_q[31:16];
	assign br = edge_rd_q[47:32];
	assign bb = edge_rd_q[63:48];
	assign mnr = (p_r_q < br) ? p_r_q : br;
	assign mxl = (p_l_q > bl) ? p_l_q : bl;
	assign mnb = (p_b_q < bb) ? p_b_q : bb;
	assign mxt = (p_t_q > bt) ? p_t_q : bt;

	// overlap test: inter * 2^16 > thr * union
	always_ff @(posedge clk) begin
		idx_s1 <= iter_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
		wd_s2 <= 17'(mnr) - 17'(mxl);
		hd_s2 <= 17'(mnb) - 17'(mxt);
		wa_s2 <= 17'(p_r_q) - 17'(p_l_q);
		ha_s2 <= 17'(p_b_q) - 17'(p_t_q);
		wb_s2 <= 17'(br) - 17'(bl);
		hb_s2 <= 17'(bb) - 17'(bt);
		inter_s3 <= wd_s2 * hd_s2;
		aa_s3    <= wa_s2 * ha_s2;
		ab_s3    <= wb_s2 * hb_s2;
		pos_s3   <= (wd_s2 > 17'sd0) && (hd_s2 > 17'sd0);
		uni_s4   <= 36'(aa_s3) + 36'(ab_s3) - 36'(inter_s3);
		inter_s4 <= inter_s3;
		pos_s4   <= pos_s3;
		prod_s5  <= 54'($signed({1'b0, thr_q})) * 54'(uni_s4);
		inter_s5 <= inter_s4;
		pos_s5   <= pos_s4;
	end

	assign sts.found     = found_q;
	assign sts.iter_last = ({1'b0, iter_q} + 1'b1) == (IW + 1)'(count_q);
	assign sts.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

endmodule

FILE: design/greedy_box_nms.sv
// Greedy non-maximum suppression over one set of scored boxes.
// Request channel: a box is taken at a rising edge with start high and busy
// low. Boxes are stored until a request with last_in high closes the set;
// boxes beyond MAX_BOXES are dropped and overflow_out is raised on every
// result of that set.
// Result channel: each kept box appears for one cycle with done high, in
// order of decreasing score (earlier arrival wins ties); last_out marks the
// final kept box. The receiver cannot stall: results must be taken as shown.
// Config: cfg_we/cfg_wdata write the Q0.16 IoU threshold; the user must
// write it only while idle, the block itself does not enforce this.
// Operation: a box that does not close the set leaves the block idle. After
// the last box, each pick is a search scan over the N held boxes, a read of
// the picked box, and an overlap scan over them followed by the drain of the
// overlap pipeline; a final search that finds no live box ends the set.
// Run time is set by the single read port of the box store, which every
// scan walks one entry per cycle. busy falls with the final result.
// Reset: empties the store, threshold returns to 56361, block is idle.
module greedy_box_nms
	import gbn_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic        [15:0] cfg_wdata,
	input  logic        [15:0] score_in,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] top_in,
	input  logic signed [15:0] right_in,
	input  logic signed [15:0] bottom_in,
	input  logic               last_in,
	output logic               done,
	output logic        [15:0] score_out,
	output logic signed [15:0] left_out,
	output logic signed [15:0] top_out,
	output logic signed [15:0] right_out,
	output logic signed [15:0] bottom_out,
	output logic               last_out,
	output logic               overflow_out
);

	cmd_t cmd;  // controller commands
	sts_t sts;  // datapath status

	gbn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_in (last_in),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	// store, search, overlap pipeline, result register
	gbn_dpath #(
		.MAX_BOXES (MAX_BOXES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.score_in     (score_in),
		.left_in      (left_in),
		.top_in       (top_in),
		.right_in     (right_in),
		.bottom_in    (bottom_in),
		.done         (done),
		.score_out    (score_out),
		.left_out     (left_out),
		.top_out      (top_out),
		.right_out    (right_out),
		.bottom_out   (bottom_out),
		.last_out     (last_out),
		.overflow_out (overflow_out)
	);

endmodule

FILE: design/gbn_checker.sv
module gbn_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in,
	input logic done,
	input logic last_out
);

	// closing request starts processing
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_in |=> busy)
		else $error("closing request did not start processing");

	// final result ends processing
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_out |-> !busy)
		else $error("busy after final result");

	// more results still to come
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_out |-> busy)
		else $error("idle between results of a set");

	// results only come out of processing
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without processing");

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.last_in  (last_in),
	.done     (done),
	.last_out (last_out)
);

FILE: tb/greedy_box_nms_test.sv
module greedy_box_nms_test;
	import gbn_pkg::*;

	typedef struct {
		logic [15:0] score;
		logic signed [15:0] l, t, r, b;
		logic last, ovf;
	} kept_box_t;

	// Golden NMS predictor: holds the open set and the queue of kept boxes.
	class nms_scoreboard;
		logic [15:0] thr;
		logic [15:0] scores[64];
		logic signed [15:0] lft[64], tp[64], rgt[64], btm[64];
		bit gone[64];
		int count;
		bit ovf;
		kept_box_t kept_q[$];
		int errors;

		function new();
			thr = THR_RESET;
			count = 0;
			ovf = 0;
			errors = 0;
		endfunction

		function bit too_close(int a, int c);
			longint w, h, inter, uni;
			w = ((rgt[a] < rgt[c]) ? rgt[a] : rgt[c]) - ((lft[a] > lft[c]) ? lft[a] : lft[c]);
			h = ((btm[a] < btm[c]) ? btm[a] : btm[c]) - ((tp[a] > tp[c]) ? tp[a] : tp[c]);
			if (w <= 0 || h <= 0)
				return 0;
			inter = w * h;
			uni = (longint'(rgt[a]) - longint'(lft[a])) * (longint'(btm[a]) - longint'(tp[a]))
				+ (longint'(rgt[c]) - longint'(lft[c])) * (longint'(btm[c]) - longint'(tp[c]))
				- inter;
			return inter * 65536 > longint'(thr) * uni;
		endfunction

		// note one accepted request
		function void note_box(logic [15:0] s, logic signed [15:0] l, t, r, b, logic last);
			int best, i;
			kept_box_t k;
			if (count < 64) begin
				scores[count] = s;
				lft[count] = l;
				tp[count] = t;
				rgt[count] = r;
				btm[count] = b;
				gone[count] = 0;
				count++;
			end else begin
				ovf = 1;
			end
			if (!last)
				return;
			forever begin
				best = -1;
				for (i = 0; i < count; i++)
					if (!gone[i] && (best < 0 || scores[i] > scores[best]))
						best = i;
				if (best < 0)
					break;
				gone[best] = 1;
				for (i = 0; i < count; i++)
					if (!gone[i] && too_close(best, i))
						gone[i] = 1;
				k.score = scores[best];
				k.l = lft[best];
				k.t = tp[best];
				k.r = rgt[best];
				k.b = btm[best];
				k.last = 0;
				k.ovf = ovf;
				kept_q.insert(kept_q.size(), k);
			end
			kept_q[kept_q.size() - 1].last = 1;
			count = 0;
			ovf = 0;
		endfunction

		function void check_result(kept_box_t act);
			kept_box_t e;
			if (kept_q.size() == 0) begin
				$error("unexpected result score=%0h", act.score);
				errors++;
				return;
			end
			e = kept_q.pop_front();
			if (act.score !== e.score) begin
				$error("score_out exp %0h got %0h", e.score, act.score);
				errors++;
			end
			if (act.l !== e.l) begin
				$error("left_out exp %0d got %0d", e.l, act.l);
				errors++;
			end
			if (act.t !== e.t) begin
				$error("top_out exp %0d got %0d", e.t, act.t);
				errors++;
			end
			if (act.r !== e.r) begin
				$error("right_out exp %0d got %0d", e.r, act.r);
				errors++;
			end
			if (act.b !== e.b) begin
				$error("bottom_out exp %0d got %0d", e.b, act.b);
				errors++;
			end
			if (act.last !== e.last) begin
				$error("last_out exp %0b got %0b", e.last, act.last);
				errors++;
			end
			if (act.ovf !== e.ovf) begin
				$error("overflow_out exp %0b got %0b", e.ovf, act.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = 0;
	logic [15:0] score_in = 0;
	logic signed [15:0] left_in = 0, top_in = 0, right_in = 0, bottom_in = 0;
	logic last_in = 0;
	logic done;
	logic [15:0] score_out;
	logic signed [15:0] left_out, top_out, right_out, bottom_out;
	logic last_out, overflow_out;

	nms_scoreboard board = new();

	greedy_box_nms DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.score_in(score_in), .left_in(left_in), .top_in(top_in),
		.right_in(right_in), .bottom_in(bottom_in), .last_in(last_in),
		.done(done), .score_out(score_out), .left_out(left_out),
		.top_out(top_out), .right_out(right_out), .bottom_out(bottom_out),
		.last_out(last_out), .overflow_out(overflow_out)
	);

	always #4 clk = ~clk;

	// Results cannot be stalled: grab every strobed one at the rising edge.
	always @(posedge clk) begin
		kept_box_t a;
		if (arst_n && done) begin
			a.score = score_out;
			a.l = left_out;
			a.t = top_out;
			a.r = right_out;
			a.b = bottom_out;
			a.last = last_out;
			a.ovf = overflow_out;
			board.check_result(a);
		end
	end

	// Mostly short gaps, now and then a long one, sometimes none.
	// With no gap start stays high for the next request.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 4) ? 0
			: ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (n > 0)
			start <= 0;
		repeat (n) @(negedge clk);
	endtask

	// Present one request, hold it until taken, model it at acceptance.
	// start is left high; the caller drops it before any gap.
	task automatic send_box(logic [15:0] s, logic signed [15:0] l, t, r, b, logic last);
		start <= 1;
		score_in <= s;
		left_in <= l;
		top_in <= t;
		right_in <= r;
		bottom_in <= b;
		last_in <= last;
		do @(posedge clk); while (busy);
		board.note_box(s, l, t, r, b, last);
		@(negedge clk);
	endtask

	// Random box; mostly small sizes near the origin so overlaps are common.
	task automatic send_rand_box(logic last);
		logic signed [15:0] l, t, r, b;
		int cx, cy;
		if ($urandom_range(0, 9) == 0) begin
			l = 16'($urandom); t = 16'($urandom); r = 16'($urandom); b = 16'($urandom);
		end else begin
			cx = int'($urandom_range(0, 1200)) - 600;
			cy = int'($urandom_range(0, 1200)) - 600;
			l = 16'(cx);
			t = 16'(cy);
			r = 16'(cx + int'($urandom_range(0, 700)));
			b = 16'(cy + int'($urandom_range(0, 700)));
		end
		send_box(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
			l, t, r, b, last);
		idle_gap();
	endtask

	// Threshold changes only once the block has drained.
	task automatic set_threshold(logic [15:0] v);
		start <= 0;
		wait (board.kept_q.size() == 0);
		@(negedge clk);
		while (busy) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		board.thr = v;
	endtask

	initial begin
		int i, n;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// single box, extremes of every field, at reset threshold
		send_box(16'hFFFF, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1);
		// equal scores: earlier arrival wins, identical box suppressed
		send_box(16'h1234, 0, 0, 100, 100, 0);
		send_box(16'h1234, 0, 0, 100, 100, 0);
		// disjoint, edge touching, inverted
		send_box(16'h0000, 200, 200, 300, 300, 0);
		send_box(16'h0001, 100, 0, 200, 100, 0);
		send_box(16'h8000, 50, 50, 10, 10, 1);
		// threshold zero: any positive overlap suppresses
		set_threshold(16'h0000);
		send_box(16'h9000, 0, 0, 1000, 1000, 0);
		send_box(16'h8000, 999, 999, 2000, 2000, 0);
		send_box(16'h7000, 1000, 0, 2000, 1000, 1);
		// highest threshold: nothing but exact full overlap can beat it
		set_threshold(16'hFFFF);
		send_box(16'h5555, 0, 0, 4096, 4096, 0);
		send_box(16'h5555, 0, 0, 4096, 4096, 0);
		send_box(16'hAAAA, 1, 1, 4096, 4096, 1);
		// overflow: 65 boxes, the last one dropped
		set_threshold(16'd32768);
		for (i = 0; i < 65; i++)
			send_box(16'($urandom), 16'(i * 50), 0, 16'(i * 50 + 80), 80, i == 64);

		// random sets, threshold reshuffled between a few of them
		n = 0;
		while (n < 195) begin
			if ($urandom_range(0, 4) == 0)
				set_threshold(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
					: 16'($urandom));
			i = $urandom_range(1, ($urandom_range(0, 19) == 0) ? 70 : 12);
			repeat (i - 1) begin
				send_rand_box(0);
				n++;
			end
			send_rand_box(1);
			n++;
		end
		start <= 0;

		wait (board.kept_q.size() == 0);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.kept_q.size() == 0)
			$display("greedy_box_nms verification clean");
		else
			$display("greedy_box_nms verification failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("greedy_box_nms verification failed");
		$finish;
	end
endmodule

FILE: greedy_box_nms.f
design/gbn_pkg.sv
design/gbn_ctrl.sv
design/gbn_dpath.sv
design/greedy_box_nms.sv
design/gbn_checker.sv
tb/greedy_box_nms_test.sv
